// ----- hdl/wall_balance_pid_wheel_speed_macros.svh -----
// Assertion macros for the wall-balance wheel speed controller.
`ifndef WALL_BALANCE_PID_WHEEL_SPEED_MACROS_SVH
`define WALL_BALANCE_PID_WHEEL_SPEED_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on clk, quiet while rst_n is low.
`define WBPID_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on clk, quiet while rst_n is low.
`define WBPID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WBPID_ASSERT_NOW(lbl, ante, cons, msg)
`define WBPID_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hdl/wbpid_pkg.sv -----
// Shared types and constants of the wall-balance wheel speed controller.
`timescale 1ns / 1ps

package wbpid_pkg;

  localparam int GAIN_BITS  = 24;
  localparam int DB_BITS    = 12;
  localparam int LIM_BITS   = 15;
  localparam int SPEED_BITS = 16;
  localparam int CORR_BITS  = 20;
  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 32;

  localparam logic [GAIN_BITS-1:0] PROP_GAIN_RST  = 24'd328;
  localparam logic [GAIN_BITS-1:0] INTEG_GAIN_RST = 24'd0;
  localparam logic [GAIN_BITS-1:0] DERIV_GAIN_RST = 24'd9830;
  localparam logic [DB_BITS-1:0]   DEAD_BAND_RST  = 12'd50;
  localparam logic [LIM_BITS-1:0]  SPEED_LIM_RST  = 15'd25723;
  localparam logic [LIM_BITS-1:0]  START_SPD_RST  = 15'd12861;

  typedef logic signed [SPEED_BITS-1:0] speed_t;
  typedef logic signed [CORR_BITS-1:0]  corr_t;

  typedef enum logic [2:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_DEAD_BAND   = 3'd3,
    REG_SPEED_LIMIT = 3'd4,
    REG_START_SPEED = 3'd5
  } reg_idx_t;

endpackage

// ----- hdl/wbpid_if.sv -----
// Request channel interfaces: distance readings in, wheel speeds out.
`timescale 1ns / 1ps

interface wbpid_in_if #(
  parameter int SENSOR_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic [SENSOR_BITS-1:0] left_distance;
  logic [SENSOR_BITS-1:0] right_distance;

  modport source (output valid, output left_distance, output right_distance, input ready);
  modport sink   (input valid, input left_distance, input right_distance, output ready);
endinterface

interface wbpid_out_if ();
  import wbpid_pkg::*;
  logic   valid;
  logic   ready;
  speed_t left_speed;
  speed_t right_speed;

  modport source (output valid, output left_speed, output right_speed, input ready);
  modport sink   (input valid, input left_speed, input right_speed, output ready);
endinterface

// ----- hdl/wall_balance_pid_wheel_speed.sv -----
// Wall-balance PID controller producing left and right wheel speed commands.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  in_ch    | sink      | valid / ready      | left_distance, right_distance
//  out_ch   | source    | valid / ready      | left_speed, right_speed (Q4.12)
//  cfg_*    | APB slave | psel/penable/pready| six registers at 4*index
//
// One request per cycle sustained while out_ch.ready stays high; a result passes through
// five register stages (input, error/integral, products, partial sums, correction) and
// the speed register that also serves as output.
// Each stage holds while the one after it is full and cannot move on, so requests keep
// flowing into empty stages while a result waits; in_ch.ready falls only when all are full.
// rst_n is synchronous; no clearing pass is needed after it.
`timescale 1ns / 1ps
`include "wall_balance_pid_wheel_speed_macros.svh"

module wall_balance_pid_wheel_speed #(
  parameter int SENSOR_BITS = 12,
  parameter int SUM_BITS    = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  wbpid_in_if.sink                          in_ch,
  wbpid_out_if.source                       out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [wbpid_pkg::ADDR_BITS-1:0]   cfg_paddr,
  input  logic [wbpid_pkg::DATA_BITS-1:0]   cfg_pwdata,
  output logic [wbpid_pkg::DATA_BITS-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import wbpid_pkg::*;

  localparam int ERR_W = SENSOR_BITS + 1;
  localparam int DIF_W = SENSOR_BITS + 2;
  localparam int ACC_W = ((SUM_BITS > ERR_W) ? SUM_BITS : ERR_W) + 1;
  localparam int CMP_W = ((SENSOR_BITS > DB_BITS) ? SENSOR_BITS : DB_BITS) + 1;
  localparam int LO_W  = SUM_BITS / 2;
  localparam int HI_W  = SUM_BITS - LO_W;
  localparam int P_W   = GAIN_BITS + 1 + ERR_W;
  localparam int D_W   = GAIN_BITS + 1 + DIF_W;
  localparam int ILO_W = GAIN_BITS + LO_W;
  localparam int IHI_W = GAIN_BITS + 1 + HI_W;
  localparam int TW    = SUM_BITS + 28;
  localparam int SUMS_W = SPEED_BITS + 5;

  localparam logic signed [ACC_W-1:0] SUM_MAX =
    {{(ACC_W-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SUM_MIN = ~SUM_MAX;
  localparam logic signed [TW-1:0] CORR_MAX =
    {{(TW-CORR_BITS+1){1'b0}}, {(CORR_BITS-1){1'b1}}};
  localparam logic signed [TW-1:0] CORR_MIN = ~CORR_MAX;
  localparam logic signed [TW-1:0] ROUND_HALF = {{(TW-4){1'b0}}, 4'd8};

  // configuration registers
  logic [GAIN_BITS-1:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [DB_BITS-1:0]   dead_band_r;
  logic [LIM_BITS-1:0]  speed_limit_r, start_speed_r;

  // pipeline control
  logic v0_r, v1_r, v2_r, v3_r, out_valid_r;
  logic v4_r;
  logic ld0, ld1, ld2, ld3, ld4, ld_out;

  // stage payloads and architectural state
  logic [SENSOR_BITS-1:0]     left_r, right_r;
  logic signed [SUM_BITS-1:0] error_sum_r;
  logic signed [ERR_W-1:0]    prev_error_r;
  logic signed [DIF_W-1:0]    diff1_r;
  logic                       upd1_r, upd2_r, upd3_r;
  logic signed [P_W-1:0]      p2_r;
  logic signed [D_W-1:0]      d2_r;
  logic [ILO_W-1:0]           ilo2_r;
  logic signed [IHI_W-1:0]    ihi2_r;
  logic signed [TW-1:0]       itot3_r, pd3_r;
  corr_t                      correction_r;
  speed_t                     left_speed_r, right_speed_r;

  logic cfg_wr;
  reg_idx_t cfg_idx;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r   <= PROP_GAIN_RST;
      integ_gain_r  <= INTEG_GAIN_RST;
      deriv_gain_r  <= DERIV_GAIN_RST;
      dead_band_r   <= DEAD_BAND_RST;
      speed_limit_r <= SPEED_LIM_RST;
      start_speed_r <= START_SPD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PROP_GAIN:   prop_gain_r   <= cfg_pwdata[GAIN_BITS-1:0];
        REG_INTEG_GAIN:  integ_gain_r  <= cfg_pwdata[GAIN_BITS-1:0];
        REG_DERIV_GAIN:  deriv_gain_r  <= cfg_pwdata[GAIN_BITS-1:0];
        REG_DEAD_BAND:   dead_band_r   <= cfg_pwdata[DB_BITS-1:0];
        REG_SPEED_LIMIT: speed_limit_r <= cfg_pwdata[LIM_BITS-1:0];
        REG_START_SPEED: start_speed_r <= cfg_pwdata[LIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PROP_GAIN:   cfg_prdata = DATA_BITS'(prop_gain_r);
      REG_INTEG_GAIN:  cfg_prdata = DATA_BITS'(integ_gain_r);
      REG_DERIV_GAIN:  cfg_prdata = DATA_BITS'(deriv_gain_r);
      REG_DEAD_BAND:   cfg_prdata = DATA_BITS'(dead_band_r);
      REG_SPEED_LIMIT: cfg_prdata = DATA_BITS'(speed_limit_r);
      REG_START_SPEED: cfg_prdata = DATA_BITS'(start_speed_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // a stage may load when it is empty or its request moves on
  assign ld_out = !out_valid_r || out_ch.ready;
  assign ld4    = !v4_r || ld_out;
  assign ld3    = !v3_r || ld4;
  assign ld2    = !v2_r || ld3;
  assign ld1    = !v1_r || ld2;
  assign ld0    = !v0_r || ld1;
  assign in_ch.ready = ld0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld0)    v0_r        <= in_ch.valid;
      if (ld1)    v1_r        <= v0_r;
      if (ld2)    v2_r        <= v1_r;
      if (ld3)    v3_r        <= v2_r;
      if (ld4)    v4_r        <= v3_r;
      if (ld_out) out_valid_r <= v4_r;
    end
  end

  // stage 0: capture the readings
  always_ff @(posedge clk) begin
    if (in_ch.valid && ld0) begin
      left_r  <= in_ch.left_distance;
      right_r <= in_ch.right_distance;
    end
  end

  // stage 1: error, deadband test, integral and difference
  logic signed [ERR_W-1:0] err;
  logic signed [ERR_W-1:0] mag;
  logic                    upd;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_sat;
  logic signed [DIF_W-1:0] diff;

  always_comb begin
    err  = $signed({1'b0, left_r}) - $signed({1'b0, right_r});
    mag  = err[ERR_W-1] ? -err : err;
    upd  = CMP_W'(mag[SENSOR_BITS-1:0]) > CMP_W'(dead_band_r);
    acc  = $signed({{(ACC_W-SUM_BITS){error_sum_r[SUM_BITS-1]}}, error_sum_r})
         + $signed({{(ACC_W-ERR_W){err[ERR_W-1]}}, err});
    if (acc > SUM_MAX) begin
      acc_sat = SUM_MAX;
    end else if (acc < SUM_MIN) begin
      acc_sat = SUM_MIN;
    end else begin
      acc_sat = acc;
    end
    diff = $signed({err[ERR_W-1], err}) - $signed({prev_error_r[ERR_W-1], prev_error_r});
  end

  // error_sum and prev_error advance only for requests outside the deadband
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      prev_error_r <= '0;
    end else if (v0_r && ld1 && upd) begin
      error_sum_r  <= acc_sat[SUM_BITS-1:0];
      prev_error_r <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (v0_r && ld1) begin
      upd1_r  <= upd;
      diff1_r <= diff;
    end
  end

  // stage 2: gain products; prev_error and error_sum hold this request's values
  // whenever its update flag is set, and the products are dropped otherwise
  always_ff @(posedge clk) begin
    if (v1_r && ld2) begin
      upd2_r <= upd1_r;
      p2_r   <= $signed({1'b0, prop_gain_r}) * prev_error_r;
      d2_r   <= $signed({1'b0, deriv_gain_r}) * diff1_r;
      ilo2_r <= integ_gain_r * error_sum_r[LO_W-1:0];
      ihi2_r <= $signed({1'b0, integ_gain_r}) * $signed(error_sum_r[SUM_BITS-1:LO_W]);
    end
  end

  // stage 3: combine the partial products
  always_ff @(posedge clk) begin
    if (v2_r && ld3) begin
      upd3_r  <= upd2_r;
      itot3_r <= (TW'(ihi2_r) <<< LO_W) + TW'($signed({1'b0, ilo2_r}));
      pd3_r   <= TW'(p2_r) + TW'(d2_r);
    end
  end

  // stage 4: round Q.16 to Q.12, saturate, or keep the old correction
  logic signed [TW-1:0] total;
  logic signed [TW-1:0] quot;
  corr_t                corr_new;
  corr_t                corr_sel;

  always_comb begin
    total = itot3_r + pd3_r + ROUND_HALF;
    quot  = total >>> 4;
    if (quot > CORR_MAX) begin
      corr_new = CORR_MAX[CORR_BITS-1:0];
    end else if (quot < CORR_MIN) begin
      corr_new = CORR_MIN[CORR_BITS-1:0];
    end else begin
      corr_new = quot[CORR_BITS-1:0];
    end
    corr_sel = upd3_r ? corr_new : correction_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      correction_r <= '0;
    end else if (v3_r && ld4) begin
      correction_r <= corr_sel;
    end
  end

  // output stage: accumulate and limit both speeds; these registers drive out_ch
  logic signed [SUMS_W-1:0] lim_pos, lim_neg;
  logic signed [SUMS_W-1:0] lsum, rsum, lclip, rclip;

  always_comb begin
    lim_pos = $signed({{(SUMS_W-LIM_BITS){1'b0}}, speed_limit_r});
    lim_neg = -lim_pos;
    lsum = SUMS_W'(left_speed_r) + SUMS_W'(correction_r);
    rsum = SUMS_W'(right_speed_r) - SUMS_W'(correction_r);
    if (lsum > lim_pos) begin
      lclip = lim_pos;
    end else if (lsum < lim_neg) begin
      lclip = lim_neg;
    end else begin
      lclip = lsum;
    end
    if (rsum > lim_pos) begin
      rclip = lim_pos;
    end else if (rsum < lim_neg) begin
      rclip = lim_neg;
    end else begin
      rclip = rsum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_speed_r  <= speed_t'({1'b0, START_SPD_RST});
      right_speed_r <= speed_t'({1'b0, START_SPD_RST});
    end else if (cfg_wr && (cfg_idx == REG_START_SPEED)) begin
      left_speed_r  <= speed_t'({1'b0, cfg_pwdata[LIM_BITS-1:0]});
      right_speed_r <= speed_t'({1'b0, cfg_pwdata[LIM_BITS-1:0]});
    end else if (v4_r && ld_out) begin
      left_speed_r  <= lclip[SPEED_BITS-1:0];
      right_speed_r <= rclip[SPEED_BITS-1:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.left_speed  = left_speed_r;
  assign out_ch.right_speed = right_speed_r;

  `WBPID_ASSERT_NOW(a_full_when_blocked, !in_ch.ready,
    v0_r && v1_r && v2_r && v3_r && v4_r && out_valid_r,
    "input blocked while a stage is empty")
  `WBPID_ASSERT_NEXT(a_sum_hold, rst_n && !(v0_r && ld1 && upd),
    $stable(error_sum_r) && $stable(prev_error_r),
    "integral state moved without an update request")
  `WBPID_ASSERT_NEXT(a_corr_hold, rst_n && !(v3_r && ld4 && upd3_r),
    $stable(correction_r),
    "correction moved inside the deadband")
  `WBPID_ASSERT_NEXT(a_speed_hold,
    rst_n && !(v4_r && ld_out) && !(cfg_wr && (cfg_idx == REG_START_SPEED)),
    $stable(left_speed_r) && $stable(right_speed_r),
    "speed changed without a result or start speed write")

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the wall-balance PID wheel speed controller.
`timescale 1ns / 1ps

module testbench;
  import wbpid_pkg::*;

  localparam int SENSOR_W       = 12;
  localparam int SUM_W          = 24;
  localparam int REG_STRIDE     = 4;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam longint SUM_HI  = (longint'(1) << (SUM_W - 1)) - 1;
  localparam longint SUM_LO  = -SUM_HI - 1;
  localparam longint CORR_HI = (longint'(1) << (CORR_BITS - 1)) - 1;
  localparam longint CORR_LO = -CORR_HI - 1;

  typedef logic [SENSOR_W-1:0] reading_t;
  localparam reading_t READ_MAX = '1;

  typedef struct packed {
    speed_t left;
    speed_t right;
  } speed_pair_t;

  class wheel_speed_scoreboard;
    logic [GAIN_BITS-1:0] kp, ki, kd;
    logic [DB_BITS-1:0]   band;
    logic [LIM_BITS-1:0]  limit;
    logic signed [SUM_W-1:0]  err_sum;
    logic signed [SENSOR_W:0] last_err;
    corr_t       corr;
    speed_t      left_spd, right_spd;
    speed_pair_t due_speeds[$];
    int requests, checked, errors, updates, held;
    int sum_clips, corr_clips, speed_clamps;

    function new();
      kp        = PROP_GAIN_RST;
      ki        = INTEG_GAIN_RST;
      kd        = DERIV_GAIN_RST;
      band      = DEAD_BAND_RST;
      limit     = SPEED_LIM_RST;
      err_sum   = '0;
      last_err  = '0;
      corr      = '0;
      left_spd  = speed_t'(START_SPD_RST);
      right_spd = speed_t'(START_SPD_RST);
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(int unsigned idx, logic [DATA_BITS-1:0] value);
      case (reg_idx_t'(idx))
        REG_PROP_GAIN:   kp = value[GAIN_BITS-1:0];
        REG_INTEG_GAIN:  ki = value[GAIN_BITS-1:0];
        REG_DERIV_GAIN:  kd = value[GAIN_BITS-1:0];
        REG_DEAD_BAND:   band = value[DB_BITS-1:0];
        REG_SPEED_LIMIT: limit = value[LIM_BITS-1:0];
        REG_START_SPEED: begin
          // load both wheels straight away
          left_spd  = speed_t'(value[LIM_BITS-1:0]);
          right_spd = speed_t'(value[LIM_BITS-1:0]);
        end
        default: ;
      endcase
    endfunction

    function speed_t step_speed(speed_t spd, longint delta);
      longint v;
      v = longint'(spd) + delta;
      if (v > longint'(limit) || v < -longint'(limit)) speed_clamps++;
      return speed_t'(clip(v, -longint'(limit), longint'(limit)));
    endfunction

    function void note_reading(reading_t left, reading_t right);
      longint err, mag, sum, total, q;
      err = longint'(left) - longint'(right);
      mag = (err < 0) ? -err : err;
      requests++;
      if (mag > longint'(band)) begin
        sum = longint'(err_sum) + err;
        if (sum > SUM_HI || sum < SUM_LO) sum_clips++;
        sum = clip(sum, SUM_LO, SUM_HI);
        total = longint'(kp) * err + longint'(kd) * (err - longint'(last_err))
              + longint'(ki) * sum;
        // round Q.16 to Q.12: floor((total + 8) / 16)
        q = (total + 8) >>> 4;
        if (q > CORR_HI || q < CORR_LO) corr_clips++;
        corr     = corr_t'(clip(q, CORR_LO, CORR_HI));
        err_sum  = sum[SUM_W-1:0];
        last_err = err[SENSOR_W:0];
        updates++;
      end else begin
        held++;
      end
      left_spd  = step_speed(left_spd, longint'(corr));
      right_spd = step_speed(right_spd, -longint'(corr));
      due_speeds.push_back('{left_spd, right_spd});
    endfunction

    function void check_speeds(speed_t left, speed_t right);
      speed_pair_t want;
      if (due_speeds.size() == 0) begin
        $display("%0t: speed request with none due: left %0d right %0d", $time, left, right);
        errors++;
        return;
      end
      want = due_speeds.pop_front();
      checked++;
      if (left !== want.left) begin
        $display("%0t: left_speed mismatch: expected %0d, got %0d", $time, want.left, left);
        errors++;
      end
      if (right !== want.right) begin
        $display("%0t: right_speed mismatch: expected %0d, got %0d", $time, want.right, right);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [ADDR_BITS-1:0]  cfg_paddr;
  logic [DATA_BITS-1:0]  cfg_pwdata;
  logic [DATA_BITS-1:0]  cfg_prdata;
  logic                  cfg_pready;

  wbpid_in_if #(.SENSOR_BITS(SENSOR_W)) in_ch ();
  wbpid_out_if out_ch ();

  wheel_speed_scoreboard sb;
  bit in_calm;
  int settings;

  wall_balance_pid_wheel_speed #(
    .SENSOR_BITS(SENSOR_W),
    .SUM_BITS   (SUM_W)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic apb_write(input int unsigned idx, input logic [DATA_BITS-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_BITS'(idx * REG_STRIDE);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // random bits above the field must be dropped by the register
  function automatic logic [DATA_BITS-1:0] with_junk(logic [DATA_BITS-1:0] field, int width);
    return (DATA_BITS'($urandom) << width) | field;
  endfunction

  task automatic program_regs(input logic [GAIN_BITS-1:0] p, i, d,
                              input logic [DB_BITS-1:0] b,
                              input logic [LIM_BITS-1:0] lim, st);
    apb_write(REG_PROP_GAIN,   with_junk(DATA_BITS'(p), GAIN_BITS));
    apb_write(REG_INTEG_GAIN,  with_junk(DATA_BITS'(i), GAIN_BITS));
    apb_write(REG_DERIV_GAIN,  with_junk(DATA_BITS'(d), GAIN_BITS));
    apb_write(REG_DEAD_BAND,   with_junk(DATA_BITS'(b), DB_BITS));
    apb_write(REG_SPEED_LIMIT, with_junk(DATA_BITS'(lim), LIM_BITS));
    apb_write(REG_START_SPEED, with_junk(DATA_BITS'(st), LIM_BITS));
    settings++;
  endtask

  task automatic send_reading(input reading_t left, input reading_t right);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 4);
    if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.left_distance  <= left;
    in_ch.right_distance <= right;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_reading(left, right);
  endtask

  task automatic send_random();
    int l, r, off, mode;
    mode = $urandom_range(0, 7);
    l = $urandom_range(0, int'(READ_MAX));
    r = $urandom_range(0, int'(READ_MAX));
    if (mode < 3) begin
      // straddle the deadband edge
      off = $urandom_range(0, int'(sb.band) + 2);
      r = $urandom_range(0, 1) ? l + off : l - off;
      if (r < 0) r = 0;
      if (r > int'(READ_MAX)) r = int'(READ_MAX);
    end else if (mode == 3) begin
      l = $urandom_range(0, 1) ? int'(READ_MAX) : 0;
      r = $urandom_range(0, 1) ? int'(READ_MAX) : 0;
    end
    send_reading(reading_t'(l), reading_t'(r));
  endtask

  // drop valid, drain every due result, then let the pipeline settle
  task automatic end_phase();
    in_ch.valid <= 1'b0;
    while (sb.due_speeds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [GAIN_BITS-1:0] pick_gain();
    int sel;
    sel = $urandom_range(0, 4);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel == 2) return GAIN_BITS'($urandom_range(0, 4096));
    return GAIN_BITS'($urandom);
  endfunction

  function automatic logic [DB_BITS-1:0] pick_band();
    int sel;
    sel = $urandom_range(0, 5);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel < 4) return DB_BITS'($urandom_range(0, 200));
    return DB_BITS'($urandom);
  endfunction

  function automatic logic [LIM_BITS-1:0] pick_speed();
    int sel;
    sel = $urandom_range(0, 4);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return LIM_BITS'($urandom);
  endfunction

  // result side: random back-pressure with calm stretches
  initial begin
    int  stall;
    bit  calm;
    calm = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if ($urandom_range(0, 39) == 0) calm = !calm;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_speeds(out_ch.left_speed, out_ch.right_speed);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    reading_t base;
    int unsigned idx;
    sb = new();
    in_calm              = 1'b0;
    settings             = 1;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.left_distance  = '0;
    in_ch.right_distance = '0;
    out_ch.ready         = 1'b0;
    cfg_psel             = 1'b0;
    cfg_penable          = 1'b0;
    cfg_pwrite           = 1'b0;
    cfg_paddr            = '0;
    cfg_pwdata           = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, field extremes, both sides of the deadband edge
    base = reading_t'(DEAD_BAND_RST);
    send_reading('0, '0);
    send_reading(READ_MAX, '0);
    send_reading('0, READ_MAX);
    send_reading(READ_MAX, READ_MAX);
    send_reading(base + reading_t'(DEAD_BAND_RST), base);
    send_reading(base, base + reading_t'(DEAD_BAND_RST));
    send_reading(base + reading_t'(DEAD_BAND_RST) + 1'b1, base);
    send_reading(base, base + reading_t'(DEAD_BAND_RST) + 1'b1);
    send_reading(12'h800, 12'h7FF);
    send_reading(12'h7FF, 12'h800);
    send_reading(12'h001, 12'h000);
    send_reading(12'h000, 12'h001);
    send_reading(12'hAAA, 12'h555);
    send_reading(12'h555, 12'hAAA);
    repeat (4) send_reading(READ_MAX, '0);
    end_phase();

    // writes to unused indexes must change nothing
    for (idx = REG_START_SPEED + 1; idx < (1 << ADDR_BITS) / REG_STRIDE; idx++)
      apb_write(idx, DATA_BITS'($urandom));
    send_reading(READ_MAX, '0);
    send_reading('0, READ_MAX);
    send_reading('0, '0);
    end_phase();

    // full gains, no deadband: drives the correction toward saturation on updates
    program_regs('1, '1, '1, '0, '1, '0);
    repeat (150) send_random();
    end_phase();

    // widest deadband, zero limit, start above the limit
    program_regs('0, '0, '0, '1, '0, '1);
    repeat (30) send_random();
    send_reading(READ_MAX, '0);
    send_reading('0, READ_MAX);
    end_phase();

    // drive the integral far one way, then far the other
    program_regs(GAIN_BITS'($urandom_range(0, 400)), GAIN_BITS'($urandom_range(1, 64)), '0,
                 DB_BITS'($urandom_range(0, 100)), '1, LIM_BITS'($urandom));
    repeat (120)
      send_reading(reading_t'($urandom_range(3900, 4095)), reading_t'($urandom_range(0, 150)));
    repeat (20) send_random();
    repeat (120)
      send_reading(reading_t'($urandom_range(0, 150)), reading_t'($urandom_range(3900, 4095)));
    repeat (20) send_random();
    end_phase();

    repeat (7) begin
      program_regs(pick_gain(), pick_gain(), pick_gain(), pick_band(), pick_speed(),
                   pick_speed());
      repeat ($urandom_range(150, 350)) send_random();
      end_phase();
    end

    $display("tb: %0d readings over %0d register settings, %0d speed pairs checked",
             sb.requests, settings, sb.checked);
    $display("tb: %0d PID updates, %0d held; clips: integral %0d, correction %0d, speed %0d",
             sb.updates, sb.held, sb.sum_clips, sb.corr_clips, sb.speed_clamps);
    if (sb.errors == 0 && sb.due_speeds.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
